/* rtl/core/qlsf_pkg.sv */
`timescale 1ns / 1ps

package qlsf_pkg;

  // Default configuration of the fitter.
  localparam int unsigned DEF_MAX_POINTS = 4096;
  localparam int unsigned DEF_X_BITS     = 12;
  localparam int unsigned DEF_Y_BITS     = 16;

  // Field widths of the transactions.
  localparam int unsigned X_FIELD_W = 12;
  localparam int unsigned Y_FIELD_W = 16;
  localparam int unsigned COEF_W    = 64;

  // Exact solver arithmetic: 256-bit words, 64-bit matrix entries, Q24.40 results.
  localparam int unsigned BIG_W     = 256;
  localparam int unsigned ENT_W     = 64;
  localparam int unsigned FRAC_BITS = 40;

  localparam logic [COEF_W-1:0] COEF_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic signed [X_FIELD_W-1:0] x;
    logic signed [Y_FIELD_W-1:0] y;
    logic                        last;
  } in_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic                     singular;
    logic                     overflowed;
  } out_item_t;

  // Update applied to the solver registers once a product is ready.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TMP_LOAD,
    OP_TMP_SUB,
    OP_ACC_ADD,
    OP_ACC_SUB
  } apply_op_e;

  typedef struct packed {
    logic       load_in;
    logic       sq;
    logic       cube;
    logic       acc_en;
    logic       det_clr;
    logic       mul_start;
    logic       a_tmp;
    logic [1:0] det_k;
    logic [1:0] a_row;
    logic [1:0] a_col;
    logic [1:0] b_row;
    logic [1:0] b_col;
    apply_op_e  op;
    logic       save_d;
    logic       div_start;
    logic       div_round;
    logic       div_sat;
    logic [1:0] coef_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic mul_busy;
    logic div_busy;
    logic acc_zero;
  } sts_t;

endpackage

/* rtl/core/qlsf_ctrl.sv */
`timescale 1ns / 1ps

module qlsf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  qlsf_pkg::sts_t  sts_i,
  output qlsf_pkg::cmd_t  cmd_o
);
  import qlsf_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SQ      = 4'd1;
  localparam logic [3:0] ST_CUBE    = 4'd2;
  localparam logic [3:0] ST_ACC     = 4'd3;
  localparam logic [3:0] ST_MUL_GO  = 4'd4;
  localparam logic [3:0] ST_MUL_RUN = 4'd5;
  localparam logic [3:0] ST_APPLY   = 4'd6;
  localparam logic [3:0] ST_DET_END = 4'd7;
  localparam logic [3:0] ST_DIV_GO  = 4'd8;
  localparam logic [3:0] ST_DIV_RUN = 4'd9;
  localparam logic [3:0] ST_DIV_RND = 4'd10;
  localparam logic [3:0] ST_DIV_SAT = 4'd11;
  localparam logic [3:0] ST_OUT     = 4'd12;

  logic [3:0] state_q, state_d;
  logic [1:0] k_q, k_d;
  logic [1:0] j_q, j_d;
  logic [1:0] s_q, s_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] c1, c2;
  logic       out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Columns of the 2x2 minor that belongs to the current cofactor term.
  assign c1 = (j_q == 2'd0) ? 2'd1 : 2'd0;
  assign c2 = (j_q == 2'd2) ? 2'd1 : 2'd2;

  // Sequencing of accumulation, determinants and divisions.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    k_d     = k_q;
    j_d     = j_q;
    s_d     = s_q;

    cmd_o.det_k    = k_q;
    cmd_o.coef_sel = 2'(k_q - 2'd1);
    case (s_q)
      2'd0: begin
        cmd_o.a_row = 2'd1;
        cmd_o.a_col = c1;
        cmd_o.b_row = 2'd2;
        cmd_o.b_col = c2;
      end
      2'd1: begin
        cmd_o.a_row = 2'd1;
        cmd_o.a_col = c2;
        cmd_o.b_row = 2'd2;
        cmd_o.b_col = c1;
      end
      default: begin
        cmd_o.a_tmp = 1'b1;
        cmd_o.b_row = 2'd0;
        cmd_o.b_col = j_q;
      end
    endcase

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = ST_CUBE;
      end
      ST_CUBE: begin
        cmd_o.cube = 1'b1;
        state_d    = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (sts_i.last) begin
          cmd_o.det_clr = 1'b1;
          k_d           = 2'd0;
          j_d           = 2'd0;
          s_d           = 2'd0;
          state_d       = ST_MUL_GO;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_MUL_RUN;
      end
      ST_MUL_RUN: begin
        if (!sts_i.mul_busy) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        case (s_q)
          2'd0:    cmd_o.op = OP_TMP_LOAD;
          2'd1:    cmd_o.op = OP_TMP_SUB;
          default: cmd_o.op = (j_q == 2'd1) ? OP_ACC_SUB : OP_ACC_ADD;
        endcase
        if (s_q != 2'd2) begin
          s_d     = 2'(s_q + 2'd1);
          state_d = ST_MUL_GO;
        end else if (j_q != 2'd2) begin
          s_d     = 2'd0;
          j_d     = 2'(j_q + 2'd1);
          state_d = ST_MUL_GO;
        end else begin
          state_d = ST_DET_END;
        end
      end
      ST_DET_END: begin
        if (k_q == 2'd0) begin
          cmd_o.save_d = 1'b1;
          if (sts_i.acc_zero) begin
            state_d = ST_OUT;
          end else begin
            cmd_o.det_clr = 1'b1;
            k_d           = 2'd1;
            j_d           = 2'd0;
            s_d           = 2'd0;
            state_d       = ST_MUL_GO;
          end
        end else begin
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (!sts_i.div_busy) begin
          state_d = ST_DIV_RND;
        end
      end
      ST_DIV_RND: begin
        cmd_o.div_round = 1'b1;
        state_d         = ST_DIV_SAT;
      end
      ST_DIV_SAT: begin
        cmd_o.div_sat = 1'b1;
        if (k_q == 2'd3) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.det_clr = 1'b1;
          k_d           = 2'(k_q + 2'd1);
          j_d           = 2'd0;
          s_d           = 2'd0;
          state_d       = ST_MUL_GO;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output transaction valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= 2'd0;
      j_q         <= 2'd0;
      s_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      j_q         <= j_d;
      s_q         <= s_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/qlsf_dp.sv */
`timescale 1ns / 1ps

module qlsf_dp #(
  parameter int unsigned MAX_POINTS = qlsf_pkg::DEF_MAX_POINTS,
  parameter int unsigned X_BITS     = qlsf_pkg::DEF_X_BITS,
  parameter int unsigned Y_BITS     = qlsf_pkg::DEF_Y_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qlsf_pkg::in_item_t  in_data_i,
  input  qlsf_pkg::cmd_t      cmd_i,
  output qlsf_pkg::sts_t      sts_o,
  output qlsf_pkg::out_item_t out_data_o
);
  import qlsf_pkg::*;

  localparam int unsigned CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int unsigned X2_W    = 2 * X_BITS;
  localparam int unsigned X3_W    = 3 * X_BITS;
  localparam int unsigned X4_W    = 4 * X_BITS;
  localparam int unsigned XY_W    = X_BITS + Y_BITS;
  localparam int unsigned X2Y_W   = 2 * X_BITS + Y_BITS;
  localparam int unsigned S1_W    = X_BITS + CNT_W;
  localparam int unsigned S2_W    = X2_W + CNT_W;
  localparam int unsigned S3_W    = X3_W + CNT_W;
  localparam int unsigned S4_W    = X4_W + CNT_W;
  localparam int unsigned SY_W    = Y_BITS + CNT_W;
  localparam int unsigned SXY_W   = XY_W + CNT_W;
  localparam int unsigned SX2Y_W  = X2Y_W + CNT_W;
  localparam int unsigned MCNT_W  = $clog2(ENT_W);
  localparam int unsigned DCNT_W  = $clog2(BIG_W);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  // Sample and per-sample powers.
  logic signed [X_BITS-1:0] x_q;
  logic signed [Y_BITS-1:0] y_q;
  logic                     last_q;
  logic signed [X2_W-1:0]   x2_q;
  logic signed [XY_W-1:0]   xy_q;
  logic signed [X3_W-1:0]   x3_q;
  logic signed [X4_W-1:0]   x4_q;
  logic signed [X2Y_W-1:0]  x2y_q;

  // Moment sums.
  logic [CNT_W-1:0]         cnt_q;
  logic signed [S1_W-1:0]   s1_q;
  logic signed [S2_W-1:0]   s2_q;
  logic signed [S3_W-1:0]   s3_q;
  logic signed [S4_W-1:0]   s4_q;
  logic signed [SY_W-1:0]   sy_q;
  logic signed [SXY_W-1:0]  sxy_q;
  logic signed [SX2Y_W-1:0] sx2y_q;
  logic                     too_many_q;

  // Solver registers.
  logic [BIG_W-1:0]  acc_q, tmp_q, d_q;
  logic              sing_q;
  logic [BIG_W-1:0]  mul_a_q, mul_p_q;
  logic [ENT_W-1:0]  mul_b_q;
  logic [MCNT_W-1:0] mul_cnt_q;
  logic              mul_busy_q;
  logic [BIG_W-1:0]  div_n_q, div_r_q, div_q_q, div_d_q;
  logic [DCNT_W-1:0] div_cnt_q;
  logic              div_busy_q, div_neg_q;
  logic [COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q;
  out_item_t         out_q;

  logic signed [ENT_W-1:0] s_ent [5];
  logic signed [ENT_W-1:0] r_ent [3];
  logic signed [ENT_W-1:0] a_ent, b_ent;
  logic                    mul_neg;
  logic [BIG_W-1:0]        mul_add;
  logic [BIG_W-1:0]        div_sh;
  logic [BIG_W:0]          div_diff;
  logic                    div_ge;
  logic                    div_rnd;
  logic [BIG_W-1:0]        n_mag, d_mag;
  logic [COEF_W-1:0]       q_mag, sat_val;

  // Matrix entries of the normal equations.
  assign s_ent[0] = ENT_W'($signed({1'b0, cnt_q}));
  assign s_ent[1] = ENT_W'(s1_q);
  assign s_ent[2] = ENT_W'(s2_q);
  assign s_ent[3] = ENT_W'(s3_q);
  assign s_ent[4] = ENT_W'(s4_q);
  assign r_ent[0] = ENT_W'(sy_q);
  assign r_ent[1] = ENT_W'(sxy_q);
  assign r_ent[2] = ENT_W'(sx2y_q);

  // Entry at (row, col) of determinant k; k selects which column holds the right side.
  function automatic logic signed [ENT_W-1:0] entry_of(input logic [1:0] k,
                                                       input logic [1:0] row,
                                                       input logic [1:0] col);
    logic [2:0] s_idx;
    logic [1:0] r_idx;
    s_idx = 3'(3'd4 - {1'b0, row} - {1'b0, col});
    r_idx = 2'(2'd2 - row);
    if (k != 2'd0 && col == 2'(k - 2'd1)) begin
      return r_ent[r_idx];
    end
    return s_ent[s_idx];
  endfunction

  always_comb begin
    a_ent = entry_of(cmd_i.det_k, cmd_i.a_row, cmd_i.a_col);
    b_ent = entry_of(cmd_i.det_k, cmd_i.b_row, cmd_i.b_col);
  end

  // Shift-add multiplier step; the top multiplier bit carries negative weight.
  assign mul_neg = (mul_cnt_q == MCNT_W'(ENT_W - 1));
  assign mul_add = mul_b_q[0] ? (mul_neg ? ~mul_a_q : mul_a_q) : '0;

  // Restoring division step.
  assign div_sh   = {div_r_q[BIG_W-2:0], div_n_q[BIG_W-1]};
  assign div_diff = {1'b0, div_sh} - {1'b0, div_d_q};
  assign div_ge   = !div_diff[BIG_W];
  assign div_rnd  = ({div_r_q, 1'b0} >= {1'b0, div_d_q});

  // Operand magnitudes for the division.
  assign n_mag = acc_q[BIG_W-1] ? BIG_W'(-acc_q) : acc_q;
  assign d_mag = d_q[BIG_W-1] ? BIG_W'(-d_q) : d_q;

  // Signed saturation of the rounded quotient.
  assign q_mag = div_q_q[COEF_W-1:0];
  always_comb begin
    if (|div_q_q[BIG_W-1:COEF_W]) begin
      sat_val = div_neg_q ? COEF_MIN : COEF_MAX;
    end else if (div_neg_q) begin
      sat_val = q_mag[COEF_W-1] ? COEF_MIN : COEF_W'(-q_mag);
    end else begin
      sat_val = q_mag[COEF_W-1] ? COEF_MAX : q_mag;
    end
  end

  // Sample capture and power products.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q    <= in_data_i.x[X_BITS-1:0];
      y_q    <= in_data_i.y[Y_BITS-1:0];
      last_q <= in_data_i.last;
    end
    if (cmd_i.sq) begin
      x2_q <= X2_W'(x_q) * X2_W'(x_q);
      xy_q <= XY_W'(x_q) * XY_W'(y_q);
    end
    if (cmd_i.cube) begin
      x3_q  <= X3_W'(x2_q) * X3_W'(x_q);
      x4_q  <= X4_W'(x2_q) * X4_W'(x2_q);
      x2y_q <= X2Y_W'(x2_q) * X2Y_W'(y_q);
    end
  end

  // Moment accumulation, cleared when a result is handed over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_q       <= '0;
      s2_q       <= '0;
      s3_q       <= '0;
      s4_q       <= '0;
      sy_q       <= '0;
      sxy_q      <= '0;
      sx2y_q     <= '0;
      too_many_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      cnt_q      <= '0;
      s1_q       <= '0;
      s2_q       <= '0;
      s3_q       <= '0;
      s4_q       <= '0;
      sy_q       <= '0;
      sxy_q      <= '0;
      sx2y_q     <= '0;
      too_many_q <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (cnt_q < CNT_MAX) begin
        cnt_q  <= CNT_W'(cnt_q + 1'b1);
        s1_q   <= s1_q + S1_W'(x_q);
        s2_q   <= s2_q + S2_W'(x2_q);
        s3_q   <= s3_q + S3_W'(x3_q);
        s4_q   <= s4_q + S4_W'(x4_q);
        sy_q   <= sy_q + SY_W'(y_q);
        sxy_q  <= sxy_q + SXY_W'(xy_q);
        sx2y_q <= sx2y_q + SX2Y_W'(x2y_q);
      end else begin
        too_many_q <= 1'b1;
      end
    end
  end

  // Unit busy flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
      div_busy_q <= 1'b0;
    end else begin
      if (cmd_i.mul_start) begin
        mul_busy_q <= 1'b1;
      end else if (mul_busy_q && mul_neg) begin
        mul_busy_q <= 1'b0;
      end
      if (cmd_i.div_start) begin
        div_busy_q <= 1'b1;
      end else if (div_busy_q && div_cnt_q == DCNT_W'(BIG_W - 1)) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  // Multiplier, determinant accumulation and divider.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mul_a_q   <= cmd_i.a_tmp ? tmp_q : BIG_W'(a_ent);
      mul_b_q   <= b_ent;
      mul_p_q   <= '0;
      mul_cnt_q <= '0;
    end else if (mul_busy_q) begin
      mul_p_q   <= mul_p_q + mul_add + BIG_W'(mul_b_q[0] & mul_neg);
      mul_a_q   <= {mul_a_q[BIG_W-2:0], 1'b0};
      mul_b_q   <= {1'b0, mul_b_q[ENT_W-1:1]};
      mul_cnt_q <= MCNT_W'(mul_cnt_q + 1'b1);
    end

    case (cmd_i.op)
      OP_TMP_LOAD: tmp_q <= mul_p_q;
      OP_TMP_SUB:  tmp_q <= tmp_q - mul_p_q;
      OP_ACC_ADD:  acc_q <= acc_q + mul_p_q;
      OP_ACC_SUB:  acc_q <= acc_q - mul_p_q;
      default: ;
    endcase
    if (cmd_i.det_clr) begin
      acc_q <= '0;
    end

    if (cmd_i.save_d) begin
      d_q    <= acc_q;
      sing_q <= sts_o.acc_zero;
    end

    if (cmd_i.div_start) begin
      div_n_q   <= n_mag << FRAC_BITS;
      div_d_q   <= d_mag;
      div_neg_q <= acc_q[BIG_W-1] ^ d_q[BIG_W-1];
      div_r_q   <= '0;
      div_q_q   <= '0;
      div_cnt_q <= '0;
    end else if (div_busy_q) begin
      div_r_q   <= div_ge ? div_diff[BIG_W-1:0] : div_sh;
      div_q_q   <= {div_q_q[BIG_W-2:0], div_ge};
      div_n_q   <= {div_n_q[BIG_W-2:0], 1'b0};
      div_cnt_q <= DCNT_W'(div_cnt_q + 1'b1);
    end else if (cmd_i.div_round) begin
      div_q_q <= div_q_q + BIG_W'(div_rnd);
    end

    if (cmd_i.div_sat) begin
      case (cmd_i.coef_sel)
        2'd0:    coef_a_q <= sat_val;
        2'd1:    coef_b_q <= sat_val;
        default: coef_c_q <= sat_val;
      endcase
    end

    if (cmd_i.out_load) begin
      out_q.coef_a     <= sing_q ? '0 : coef_a_q;
      out_q.coef_b     <= sing_q ? '0 : coef_b_q;
      out_q.coef_c     <= sing_q ? '0 : coef_c_q;
      out_q.singular   <= sing_q;
      out_q.overflowed <= too_many_q;
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.mul_busy = mul_busy_q;
  assign sts_o.div_busy = div_busy_q;
  assign sts_o.acc_zero = (acc_q == '0);
  assign out_data_o     = out_q;

endmodule

/* rtl/core/quadratic_least_squares_fit_top.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    in_data_i  (x, y, last)
// out      output     out_valid_o / out_ready_i  out_data_o (coef_a, coef_b, coef_c, flags)
//
// Each point passes through capture, two multiply stages and accumulation; the next point
// is accepted only after its accumulation. A point marked last then runs the solver: each 3x3
// determinant is 9 multiplications on the shared shift-add multiplier, each quotient a
// pass of the restoring divider; a singular set stops after the first determinant.
// Reset clears the moment sums and the controller; no clearing pass is needed.
// A result waiting on out_ready_i does not block new points; a second solve holds its
// result until the output register is free.

module quadratic_least_squares_fit_top #(
  parameter int unsigned MAX_POINTS = qlsf_pkg::DEF_MAX_POINTS,
  parameter int unsigned X_BITS     = qlsf_pkg::DEF_X_BITS,
  parameter int unsigned Y_BITS     = qlsf_pkg::DEF_Y_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qlsf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qlsf_pkg::out_item_t out_data_o
);
  import qlsf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  qlsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Moment sums and exact solver.
  qlsf_dp #(
    .MAX_POINTS (MAX_POINTS),
    .X_BITS     (X_BITS),
    .Y_BITS     (Y_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

`ifndef SYNTH
  // An accepted point keeps the block busy for the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while previous point in progress");

  // A singular result carries zero coefficients.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.singular) |->
      (out_data_o.coef_a == '0 && out_data_o.coef_b == '0 && out_data_o.coef_c == '0))
    else $error("singular result with non-zero coefficients");

  // The arithmetic units are idle whenever a new point may enter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!sts.mul_busy && !sts.div_busy))
    else $error("arithmetic unit busy while idle");
`endif

endmodule
